/* rtl/deq_pkg.sv */
// Shared types and codes for the circular deque block.
// Used by deq_cell, circular_deque_top and the testbench; depends on nothing.
package deq_pkg;

  // Default number of slots; the deque holds at most DEQ_DEPTH-1 words
  localparam int DEQ_DEPTH = 16;
  localparam int WORD_W    = 32;

  // Action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [3:0]               count;
  } deq_out_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_right;  // push front: every word moves one cell toward the back
    logic shift_left;   // pop front: every word moves one cell toward the front
    logic write_back;   // push back: the cell at the tail position loads the word
  } deq_cell_cmd_t;

endpackage

/* rtl/deq_cell.sv */
// One storage cell of the deque chain: holds one word, takes it from a neighbor or loads the pushed word.
// Depends on deq_pkg.
module deq_cell #(
  parameter int IDX = 0,
  parameter int CW  = $clog2(deq_pkg::DEQ_DEPTH)
) (
  input  logic                         clk,
  input  deq_pkg::deq_cell_cmd_t       cmd,
  input  logic [CW-1:0]                count,
  input  logic [deq_pkg::WORD_W-1:0]   left_word,
  input  logic [deq_pkg::WORD_W-1:0]   right_word,
  input  logic [deq_pkg::WORD_W-1:0]   push_word,
  output logic [deq_pkg::WORD_W-1:0]   word,
  output logic [deq_pkg::WORD_W-1:0]   tap
);

  logic [CW-1:0] last_pos;
  logic          at_tail;
  logic          at_last;

  // Locate this cell against the fill level
  assign last_pos = count - CW'(1);
  assign at_tail  = (count == CW'(IDX));
  assign at_last  = (last_pos == CW'(IDX));

  // Shift with the chain, or load the pushed word at the tail
  always_ff @(posedge clk) begin
    if (cmd.shift_right) begin
      word <= left_word;
    end else if (cmd.shift_left) begin
      word <= right_word;
    end else if (cmd.write_back && at_tail) begin
      word <= push_word;
    end
  end

  // Offer the word to the back-read tree when this cell is the back entry
  assign tap = at_last ? word : '0;

endmodule

/* rtl/circular_deque_top.sv */
// Circular deque top level: command decode, fill count, cell chain, result register.
// Depends on deq_pkg and deq_cell.
//
// Usage:
//   The request channel (req_valid/req_ready/req) carries one word per item:
//   an action (push front, push back, pop front, pop back, clear) and a value.
//   The response channel (rsp_valid/rsp_ready/rsp) returns one word per item:
//   the popped data (zero unless a pop succeeded), a status (ok, full, empty)
//   and the low four bits of the entry count after the item.
//   Entries live in a row of DEPTH-1 cells ordered front to back; cell 0 is
//   the front. Push/pop front shift the whole row one cell, push back loads
//   the cell at the fill level, pop back reads the cell just below it.
//   rsp_valid rises in the cycle after acceptance; one item is taken per
//   cycle, paced by the single response register: a new request is taken
//   whenever that register is empty or being drained in the same cycle.
//   Reset clears the fill count and the response valid; cell contents are
//   not cleared and need no clearing pass. When the receiver stalls, the
//   response holds and req_ready drops until it is taken.
module circular_deque_top #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  deq_pkg::deq_in_t   req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output deq_pkg::deq_out_t  rsp
);

  localparam int CW    = $clog2(DEPTH);
  localparam int CELLS = DEPTH - 1;

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         accept;
  logic                         is_full;
  logic                         is_empty;
  deq_pkg::deq_cell_cmd_t       cmd;
  logic [deq_pkg::WORD_W-1:0]   words [CELLS];
  logic [deq_pkg::WORD_W-1:0]   taps  [CELLS];
  logic [deq_pkg::WORD_W-1:0]   back_word;
  logic [deq_pkg::WORD_W-1:0]   data_next;
  logic [1:0]                   status_next;
  logic [CW+3:0]                count_ext;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_full   = (count == CW'(DEPTH - 1));
  assign is_empty  = (count == '0);

  // Decode the action into a chain command, result and next fill level
  always_comb begin
    cmd         = '0;
    data_next   = '0;
    status_next = deq_pkg::ST_OK;
    count_next  = count;
    case (req.action)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          cmd.shift_right = accept;
          count_next      = count + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          cmd.write_back = accept;
          count_next     = count + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          cmd.shift_left = accept;
          data_next      = words[0];
          count_next     = count - CW'(1);
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          data_next  = back_word;
          count_next = count - CW'(1);
        end
      end
      deq_pkg::ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Build the cell chain
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_word;
    logic [deq_pkg::WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = req.value;
    end else begin : g_inner_left
      assign left_word = words[i-1];
    end

    if (i == CELLS - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_right
      assign right_word = words[i+1];
    end

    deq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_word  (left_word),
      .right_word (right_word),
      .push_word  (req.value),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  // Gather the back entry; at most one cell drives a nonzero tap
  always_comb begin
    back_word = '0;
    for (int i = 0; i < CELLS; i++) begin
      back_word = back_word | taps[i];
    end
  end

  assign count_ext = (CW + 4)'(count_next);

  // Hold fill level and response word
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.data   <= data_next;
      rsp.status <= status_next;
      rsp.count  <= count_ext[3:0];
    end
  end

`ifndef NO_ASSERTIONS
  // Every accepted word produces a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("no response after accepted request");

  // The fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH - 1))
    else $error("fill count above capacity");

  // A push into a full deque reports full and leaves the count alone
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (accept && is_full && (req.action == deq_pkg::ACT_PUSH_FRONT ||
                           req.action == deq_pkg::ACT_PUSH_BACK))
    |=> (rsp.status == deq_pkg::ST_FULL) && $stable(count))
    else $error("push into full deque not refused");

  // A pop from an empty deque reports empty with zero data
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && is_empty && (req.action == deq_pkg::ACT_POP_FRONT ||
                            req.action == deq_pkg::ACT_POP_BACK))
    |=> (rsp.status == deq_pkg::ST_EMPTY) && (rsp.data == '0))
    else $error("pop from empty deque not refused");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for circular_deque_top: random and directed deque words,
// with a shadow deque that predicts every response. Depends on deq_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes the block decodes as no-ops
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int WORDS_PER_PHASE = 625;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_STALL      = 160;
  localparam int STALL_AFTER     = 200;
  localparam int SH_W            = $clog2(deq_pkg::DEQ_DEPTH);

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  deq_pkg::deq_in_t  req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  deq_pkg::deq_out_t rsp;

  // Words waiting to be offered, and responses the shadow deque says are due
  deq_pkg::deq_in_t  ops_to_send [$];
  deq_pkg::deq_out_t due_results [$];
  deq_pkg::deq_out_t want_rsp;

  // Shadow deque, kept as a circular buffer
  logic signed [deq_pkg::WORD_W-1:0] shadow_slots [deq_pkg::DEQ_DEPTH];
  int shadow_head = 0;
  int shadow_tail = 0;

  int send_idle_pct = 7;
  int rcv_idle_pct  = 67;
  int words_taken   = 0;
  int stall_left    = 0;
  bit long_stall_done = 1'b0;
  int mismatches    = 0;
  int cycle_cnt;

  circular_deque_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Apply one word to the shadow deque and return the response it should give
  function automatic deq_pkg::deq_out_t shadow_deque_op(deq_pkg::deq_in_t w);
    deq_pkg::deq_out_t r;
    bit                full_now;
    bit                empty_now;
    r         = '0;
    full_now  = ((shadow_tail + 1) % deq_pkg::DEQ_DEPTH) == shadow_head;
    empty_now = shadow_head == shadow_tail;
    case (w.action)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (full_now) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_head = (shadow_head + deq_pkg::DEQ_DEPTH - 1) % deq_pkg::DEQ_DEPTH;
          shadow_slots[SH_W'(shadow_head)] = w.value;
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (full_now) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_slots[SH_W'(shadow_tail)] = w.value;
          shadow_tail = (shadow_tail + 1) % deq_pkg::DEQ_DEPTH;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (empty_now) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_slots[SH_W'(shadow_head)];
          shadow_head = (shadow_head + 1) % deq_pkg::DEQ_DEPTH;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (empty_now) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_tail = (shadow_tail + deq_pkg::DEQ_DEPTH - 1) % deq_pkg::DEQ_DEPTH;
          r.data = shadow_slots[SH_W'(shadow_tail)];
        end
      end
      deq_pkg::ACT_CLEAR: begin
        shadow_head = 0;
        shadow_tail = 0;
      end
      default: ;
    endcase
    r.count = 4'((shadow_tail - shadow_head + deq_pkg::DEQ_DEPTH) % deq_pkg::DEQ_DEPTH);
    return r;
  endfunction

  task automatic queue_op(logic [2:0] act, logic signed [deq_pkg::WORD_W-1:0] val);
    deq_pkg::deq_in_t w;
    w.action = act;
    w.value  = val;
    ops_to_send.push_back(w);
  endtask

  // Mostly random data, with the extremes mixed in now and then
  function automatic logic signed [deq_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(15))
      0: return {1'b1, {(deq_pkg::WORD_W-1){1'b0}}};
      1: return {1'b0, {(deq_pkg::WORD_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pick an action; push_pct steers the burst toward filling or draining
  function automatic logic [2:0] rand_action(int push_pct);
    int p;
    p = $urandom_range(99);
    if (p < push_pct) begin
      return $urandom_range(1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
    end
    if (p < 97) return $urandom_range(1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
    if (p < 99) return deq_pkg::ACT_CLEAR;
    case ($urandom_range(2))
      0: return ACT_SPARE_5;
      1: return ACT_SPARE_6;
      default: return ACT_SPARE_7;
    endcase
  endfunction

  // Queue bursts that fill, drain or churn the deque
  task automatic queue_random(int n);
    int left;
    int len;
    int push_pct;
    left = n;
    while (left > 0) begin
      case ($urandom_range(3))
        0, 1: push_pct = 85;
        2: push_pct = 15;
        default: push_pct = 50;
      endcase
      len = $urandom_range(40, 8);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) queue_op(rand_action(push_pct), rand_word());
      left -= len;
    end
  endtask

  // Drive request words; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      if (req_valid && req_ready) begin
        due_results.push_back(shadow_deque_op(req));
        words_taken <= words_taken + 1;
      end
      if (!req_valid || req_ready) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req       <= ops_to_send.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Check response words and throttle rsp_ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected response word %p", rsp);
          mismatches++;
        end else begin
          want_rsp = due_results.pop_front();
          if (rsp.data !== want_rsp.data) begin
            $error("data: expected %0d, got %0d", want_rsp.data, rsp.data);
            mismatches++;
          end
          if (rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
            mismatches++;
          end
          if (rsp.count !== want_rsp.count) begin
            $error("count: expected %0d, got %0d", want_rsp.count, rsp.count);
            mismatches++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up its input
      if (!long_stall_done && words_taken >= STALL_AFTER) begin
        long_stall_done <= 1'b1;
        stall_left      <= LONG_STALL;
        rsp_ready       <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Abort a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Pops on an empty deque, spare codes, extremes at both ends
    queue_op(deq_pkg::ACT_POP_FRONT, rand_word());
    queue_op(deq_pkg::ACT_POP_BACK, rand_word());
    queue_op(ACT_SPARE_5, rand_word());
    queue_op(ACT_SPARE_6, rand_word());
    queue_op(ACT_SPARE_7, rand_word());
    queue_op(deq_pkg::ACT_PUSH_FRONT, {1'b1, {(deq_pkg::WORD_W-1){1'b0}}});
    queue_op(deq_pkg::ACT_PUSH_BACK, {1'b0, {(deq_pkg::WORD_W-1){1'b1}}});
    queue_op(deq_pkg::ACT_POP_BACK, '0);
    queue_op(deq_pkg::ACT_POP_FRONT, '1);
    // Fill from both ends, push into a full deque, then clear
    for (int k = 0; k < deq_pkg::DEQ_DEPTH - 1; k++) begin
      queue_op(k[0] ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK, rand_word());
    end
    queue_op(deq_pkg::ACT_PUSH_BACK, rand_word());
    queue_op(deq_pkg::ACT_PUSH_FRONT, rand_word());
    queue_op(deq_pkg::ACT_CLEAR, rand_word());
    queue_random(WORDS_PER_PHASE);
    while (ops_to_send.size() != 0) @(posedge clk);

    // Swap the idle rates
    send_idle_pct <= 67;
    rcv_idle_pct  <= 7;
    queue_random(WORDS_PER_PHASE);
    while (ops_to_send.size() != 0) @(posedge clk);

    // Full rate on both sides
    send_idle_pct <= 0;
    rcv_idle_pct  <= 0;
    queue_random(WORDS_PER_PHASE);
    while (ops_to_send.size() != 0 || req_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* circular_deque_top.f */
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/circular_deque_top.sv
tb/testbench.sv
